>>> hdl/tun_pkg.sv
package tun_pkg;

  // Field widths.
  localparam int COORD_BITS = 16;
  localparam int NORMAL_FRAC_BITS = 14;
  localparam int OW = NORMAL_FRAC_BITS + 2;

  // Datapath widths: edge, product, cross component, magnitude halves.
  localparam int EW = COORD_BITS + 1;
  localparam int PW = 2 * EW;
  localparam int NW = PW + 1;
  localparam int HW = (NW + 1) / 2;
  localparam int M2W = 4 * HW;
  localparam int SW = M2W + 2;
  localparam int RW = SW + 2 * NORMAL_FRAC_BITS + 4;
  localparam int LW = NORMAL_FRAC_BITS + 1;

  // Cycles from an accepted request to its result strobe.
  localparam int LAT = NORMAL_FRAC_BITS + 9;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] p1_x;
    logic signed [COORD_BITS-1:0] p1_y;
    logic signed [COORD_BITS-1:0] p1_z;
    logic signed [COORD_BITS-1:0] p2_x;
    logic signed [COORD_BITS-1:0] p2_y;
    logic signed [COORD_BITS-1:0] p2_z;
    logic signed [COORD_BITS-1:0] p3_x;
    logic signed [COORD_BITS-1:0] p3_y;
    logic signed [COORD_BITS-1:0] p3_z;
  } req_t;

  typedef struct packed {
    logic signed [OW-1:0] normal_x;
    logic signed [OW-1:0] normal_y;
    logic signed [OW-1:0] normal_z;
    logic                 degenerate;
  } res_t;

  // One lane's view of its cross component: sign and squared magnitude.
  typedef struct packed {
    logic           neg;
    logic [M2W-1:0] m2;
  } lane_t;

endpackage

>>> hdl/tun_cross.sv
module tun_cross (
  input  logic                          clk,
  input  tun_pkg::req_t                 req,
  output logic signed [tun_pkg::NW-1:0] n_x,
  output logic signed [tun_pkg::NW-1:0] n_y,
  output logic signed [tun_pkg::NW-1:0] n_z
);

  logic signed [tun_pkg::EW-1:0] ax, ay, az, bx, by, bz;
  logic signed [tun_pkg::PW-1:0] p0, p1, p2, p3, p4, p5;

  // Edge vectors relative to the first vertex.
  always_ff @(posedge clk) begin
    ax <= tun_pkg::EW'(req.p2_x) - tun_pkg::EW'(req.p1_x);
    ay <= tun_pkg::EW'(req.p2_y) - tun_pkg::EW'(req.p1_y);
    az <= tun_pkg::EW'(req.p2_z) - tun_pkg::EW'(req.p1_z);
    bx <= tun_pkg::EW'(req.p3_x) - tun_pkg::EW'(req.p1_x);
    by <= tun_pkg::EW'(req.p3_y) - tun_pkg::EW'(req.p1_y);
    bz <= tun_pkg::EW'(req.p3_z) - tun_pkg::EW'(req.p1_z);
  end

  // The six products of the cross product.
  always_ff @(posedge clk) begin
    p0 <= ay * bz;
    p1 <= az * by;
    p2 <= az * bx;
    p3 <= ax * bz;
    p4 <= ax * by;
    p5 <= ay * bx;
  end

  // Cross product components, exact.
  always_ff @(posedge clk) begin
    n_x <= tun_pkg::NW'(p0) - tun_pkg::NW'(p1);
    n_y <= tun_pkg::NW'(p2) - tun_pkg::NW'(p3);
    n_z <= tun_pkg::NW'(p4) - tun_pkg::NW'(p5);
  end

endmodule

>>> hdl/tun_square.sv
module tun_square (
  input  logic                          clk,
  input  logic signed [tun_pkg::NW-1:0] n,
  output tun_pkg::lane_t                lane
);

  logic [2*tun_pkg::HW-1:0] mag;
  logic                     neg_d;
  logic [2*tun_pkg::HW-1:0] pp_hh, pp_hl, pp_ll;

  always_comb begin
    mag = (2*tun_pkg::HW)'(n[tun_pkg::NW-1] ? -n : n);
  end

  // Partial products of the magnitude split into two halves.
  always_ff @(posedge clk) begin
    neg_d <= n[tun_pkg::NW-1];
    pp_hh <= mag[2*tun_pkg::HW-1:tun_pkg::HW] * mag[2*tun_pkg::HW-1:tun_pkg::HW];
    pp_hl <= mag[2*tun_pkg::HW-1:tun_pkg::HW] * mag[tun_pkg::HW-1:0];
    pp_ll <= mag[tun_pkg::HW-1:0] * mag[tun_pkg::HW-1:0];
  end

  // Recombine into the full square.
  always_ff @(posedge clk) begin
    lane.neg <= neg_d;
    lane.m2  <= (tun_pkg::M2W'(pp_hh) << (2*tun_pkg::HW))
              + (tun_pkg::M2W'(pp_hl) << (tun_pkg::HW + 1))
              + tun_pkg::M2W'(pp_ll);
  end

endmodule

>>> hdl/tun_merge.sv
module tun_merge (
  input  logic                   clk,
  input  tun_pkg::lane_t         lane_x,
  input  tun_pkg::lane_t         lane_y,
  input  tun_pkg::lane_t         lane_z,
  output tun_pkg::lane_t         out_x,
  output tun_pkg::lane_t         out_y,
  output tun_pkg::lane_t         out_z,
  output logic [tun_pkg::SW-1:0] s,
  output logic                   degen
);

  logic [tun_pkg::SW-1:0] sum;

  always_comb begin
    sum = tun_pkg::SW'(lane_x.m2) + tun_pkg::SW'(lane_y.m2) + tun_pkg::SW'(lane_z.m2);
  end

  // Squared length of the normal, and the lanes held alongside it.
  always_ff @(posedge clk) begin
    s     <= sum;
    degen <= (sum == '0);
    out_x <= lane_x;
    out_y <= lane_y;
    out_z <= lane_z;
  end

endmodule

>>> hdl/tun_quot.sv
module tun_quot (
  input  logic                   clk,
  input  tun_pkg::lane_t         lane,
  input  logic [tun_pkg::SW-1:0] s,
  output logic [tun_pkg::LW-1:0] mag,
  output logic                   neg
);

  localparam int F = tun_pkg::NORMAL_FRAC_BITS;

  // Per stage: residual R = 4 m^2 2^(2F) - (2k-1)^2 s and Q = (2k-1) s.
  logic signed [tun_pkg::RW-1:0] r_st [0:F+1];
  logic signed [tun_pkg::RW-1:0] q_st [0:F+1];
  logic        [tun_pkg::SW-1:0] s_st [0:F+1];
  logic        [tun_pkg::LW-1:0] k_st [0:F+1];
  logic                          n_st [0:F+1];

  logic signed [tun_pkg::RW-1:0] s_in;

  always_comb begin
    s_in = $signed({{(tun_pkg::RW-tun_pkg::SW){1'b0}}, s});
  end

  // Starting point with k = 0.
  always_ff @(posedge clk) begin
    r_st[0] <= ($signed({{(tun_pkg::RW-tun_pkg::M2W){1'b0}}, lane.m2}) <<< (2*F + 2)) - s_in;
    q_st[0] <= -s_in;
    s_st[0] <= s;
    k_st[0] <= '0;
    n_st[0] <= lane.neg;
  end

  // One result bit per stage, most significant first.
  for (genvar j = 0; j <= F; j++) begin : g_bit
    localparam int B = F - j;
    logic signed [tun_pkg::RW-1:0] s_ext;
    logic signed [tun_pkg::RW-1:0] t;
    logic                          take;

    always_comb begin
      s_ext = $signed({{(tun_pkg::RW-tun_pkg::SW){1'b0}}, s_st[j]});
      t     = r_st[j] - (q_st[j] <<< (B + 2)) - (s_ext <<< (2*B + 2));
      take  = !k_st[j][F] && !t[tun_pkg::RW-1];
    end

    always_ff @(posedge clk) begin
      s_st[j+1] <= s_st[j];
      n_st[j+1] <= n_st[j];
      if (take) begin
        r_st[j+1] <= t;
        q_st[j+1] <= q_st[j] + (s_ext <<< (B + 1));
        k_st[j+1] <= k_st[j] | (tun_pkg::LW'(1) << B);
      end else begin
        r_st[j+1] <= r_st[j];
        q_st[j+1] <= q_st[j];
        k_st[j+1] <= k_st[j];
      end
    end
  end

  assign mag = k_st[F+1];
  assign neg = n_st[F+1];

endmodule

>>> hdl/triangle_unit_normal_top.sv
// Channel   Ports                 Strobe / handshake
// request   req (tun_pkg::req_t)  start, accepted when busy is low
// result    res (tun_pkg::res_t)  done, valid for exactly one cycle
//
// Fully pipelined: a request can be accepted every cycle and busy stays low.
// The three lanes' rounding pipelines resolve one bit of the unit component per
// stage. Synchronous reset clears the strobe pipeline; data registers are not
// reset. The receiver cannot stall; each result is shown for one cycle only.
module triangle_unit_normal_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  tun_pkg::req_t req,
  output logic          done,
  output tun_pkg::res_t res
);

  localparam int F = tun_pkg::NORMAL_FRAC_BITS;

  logic signed [tun_pkg::NW-1:0] n_x, n_y, n_z;
  tun_pkg::lane_t                sq_x, sq_y, sq_z;
  tun_pkg::lane_t                mg_x, mg_y, mg_z;
  logic [tun_pkg::SW-1:0]        s;
  logic                          degen;
  logic [tun_pkg::LW-1:0]        mag_x, mag_y, mag_z;
  logic                          neg_x, neg_y, neg_z;
  logic [tun_pkg::LAT-1:0]       vld;
  logic [F+1:0]                  degen_pipe;
  tun_pkg::res_t                 res_next;

  assign busy = 1'b0;

  tun_cross u_cross (.clk(clk), .req(req), .n_x(n_x), .n_y(n_y), .n_z(n_z));

  tun_square u_sq_x (.clk(clk), .n(n_x), .lane(sq_x));
  tun_square u_sq_y (.clk(clk), .n(n_y), .lane(sq_y));
  tun_square u_sq_z (.clk(clk), .n(n_z), .lane(sq_z));

  tun_merge u_merge (
    .clk(clk), .lane_x(sq_x), .lane_y(sq_y), .lane_z(sq_z),
    .out_x(mg_x), .out_y(mg_y), .out_z(mg_z), .s(s), .degen(degen)
  );

  tun_quot u_q_x (.clk(clk), .lane(mg_x), .s(s), .mag(mag_x), .neg(neg_x));
  tun_quot u_q_y (.clk(clk), .lane(mg_y), .s(s), .mag(mag_y), .neg(neg_y));
  tun_quot u_q_z (.clk(clk), .lane(mg_z), .s(s), .mag(mag_z), .neg(neg_z));

  // Request strobe follows the data down the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[tun_pkg::LAT-2:0], start && !busy};
    end
  end

  // Degenerate flag waits out the rounding stages.
  always_ff @(posedge clk) begin
    degen_pipe <= {degen_pipe[F:0], degen};
  end

  // Apply signs; a zero-length normal gives a zero vector.
  always_comb begin
    res_next.degenerate = degen_pipe[F+1];
    res_next.normal_x = '0;
    res_next.normal_y = '0;
    res_next.normal_z = '0;
    if (!degen_pipe[F+1]) begin
      res_next.normal_x = neg_x ? -tun_pkg::OW'(mag_x) : tun_pkg::OW'(mag_x);
      res_next.normal_y = neg_y ? -tun_pkg::OW'(mag_y) : tun_pkg::OW'(mag_y);
      res_next.normal_z = neg_z ? -tun_pkg::OW'(mag_z) : tun_pkg::OW'(mag_z);
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

  assign done = vld[tun_pkg::LAT-1];

endmodule

>>> hdl/tun_check.sv
module tun_check (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input tun_pkg::res_t res
);

  localparam logic signed [tun_pkg::OW-1:0] ONE = tun_pkg::OW'(1) << tun_pkg::NORMAL_FRAC_BITS;

  // The pipeline never refuses a request.
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  // Every result strobe traces back to a request a fixed latency earlier.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, tun_pkg::LAT))
    else $error("result without matching request");

  // A degenerate triangle reports the zero vector.
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (done && res.degenerate) |->
      (res.normal_x == '0 && res.normal_y == '0 && res.normal_z == '0))
    else $error("degenerate result not zero");

  // Unit components stay within plus or minus one.
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (res.normal_x <= ONE && res.normal_x >= -ONE &&
              res.normal_y <= ONE && res.normal_y >= -ONE &&
              res.normal_z <= ONE && res.normal_z >= -ONE))
    else $error("normal component out of range");

endmodule

bind triangle_unit_normal_top tun_check u_check (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .res(res)
);

>>> tb/triangle_unit_normal_checker.sv
`timescale 1ns / 1ps

module triangle_unit_normal_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          busy,
  input  tun_pkg::req_t req,
  input  logic          done,
  input  tun_pkg::res_t res,
  output int            fail_count,
  output int            pending_normals,
  output int            checked_count,
  output int            degenerate_count
);

  tun_pkg::res_t expected_normals[$];

  // Rounds one cross component over the exact length: the largest k in [0, 1.0]
  // with (2k-1)^2 * s <= c^2 * 2^(2F+2), so ties go away from zero.
  function automatic logic [tun_pkg::OW-1:0] round_unit(longint c, logic [127:0] s);
    logic [127:0] cc;
    logic [127:0] odd;
    int           lo;
    int           cand;
    cc = (c < 0) ? 128'(-c) : 128'(c);
    cc = (cc * cc) << (2 * tun_pkg::NORMAL_FRAC_BITS + 2);
    lo = 0;
    for (int b = tun_pkg::NORMAL_FRAC_BITS; b >= 0; b--) begin
      cand = lo | (1 << b);
      if (cand <= (1 << tun_pkg::NORMAL_FRAC_BITS)) begin
        odd = 128'(2 * cand - 1);
        if (odd * odd * s <= cc) lo = cand;
      end
    end
    return (c < 0) ? tun_pkg::OW'(-lo) : tun_pkg::OW'(lo);
  endfunction

  // Face normal of one request, with exact edges and cross product.
  function automatic tun_pkg::res_t face_normal(tun_pkg::req_t r);
    longint        ax, ay, az, bx, by, bz;
    longint        n[3];
    logic [127:0]  len2;
    tun_pkg::res_t o;
    ax = longint'(r.p2_x) - longint'(r.p1_x);
    ay = longint'(r.p2_y) - longint'(r.p1_y);
    az = longint'(r.p2_z) - longint'(r.p1_z);
    bx = longint'(r.p3_x) - longint'(r.p1_x);
    by = longint'(r.p3_y) - longint'(r.p1_y);
    bz = longint'(r.p3_z) - longint'(r.p1_z);
    n[0] = ay * bz - az * by;
    n[1] = az * bx - ax * bz;
    n[2] = ax * by - ay * bx;
    len2 = 0;
    for (int i = 0; i < 3; i++) begin
      len2 += 128'(n[i] < 0 ? -n[i] : n[i]) * 128'(n[i] < 0 ? -n[i] : n[i]);
    end
    o = '0;
    if (len2 == 0) begin
      o.degenerate = 1'b1;
    end else begin
      o.normal_x = round_unit(n[0], len2);
      o.normal_y = round_unit(n[1], len2);
      o.normal_z = round_unit(n[2], len2);
    end
    return o;
  endfunction

  assign pending_normals = expected_normals.size();

  // Predict on each accepted request and compare each strobed result.
  always @(posedge clk) begin
    tun_pkg::res_t want;
    if (rst) begin
      fail_count <= 0;
      checked_count <= 0;
      degenerate_count <= 0;
    end else begin
      if (start && !busy) expected_normals = {expected_normals, face_normal(req)};
      if (done) begin
        if (expected_normals.size() == 0) begin
          $display("%0t: unexpected result %h", $time, res);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_normals.pop_front();
          checked_count <= checked_count + 1;
          if (want.degenerate) degenerate_count <= degenerate_count + 1;
          if (want.normal_x !== res.normal_x || want.normal_y !== res.normal_y ||
              want.normal_z !== res.normal_z || want.degenerate !== res.degenerate) begin
            $display({"%0t: mismatch expected x=%0d y=%0d z=%0d deg=%0b",
                      " actual x=%0d y=%0d z=%0d deg=%0b"},
                     $time, want.normal_x, want.normal_y, want.normal_z, want.degenerate,
                     res.normal_x, res.normal_y, res.normal_z, res.degenerate);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

>>> tb/triangle_unit_normal_top_test.sv
`timescale 1ns / 1ps

module triangle_unit_normal_top_test;

  localparam int RANDOM_REQUESTS = 530;
  localparam int QUIET_TAIL = 120;
  localparam int CYCLE_LIMIT = 200000;
  localparam int REQ_BITS = $bits(tun_pkg::req_t);

  logic          clk;
  logic          rst;
  logic          start;
  logic          busy;
  tun_pkg::req_t req;
  logic          done;
  tun_pkg::res_t res;
  int            fail_count;
  int            pending_normals;
  int            checked_count;
  int            degenerate_count;
  int            cycle_count = 0;
  int            sent_count;

  triangle_unit_normal_top u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done), .res(res)
  );

  triangle_unit_normal_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done), .res(res),
    .fail_count(fail_count), .pending_normals(pending_normals),
    .checked_count(checked_count), .degenerate_count(degenerate_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Holds one request on the port until accepted, then maybe idles a burst.
  task automatic send_face(tun_pkg::req_t r, bit may_idle);
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    sent_count++;
    if (may_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  function automatic tun_pkg::req_t make_face(int v[9]);
    tun_pkg::req_t r;
    r = {16'(v[0]), 16'(v[1]), 16'(v[2]), 16'(v[3]), 16'(v[4]), 16'(v[5]),
         16'(v[6]), 16'(v[7]), 16'(v[8])};
    return r;
  endfunction

  function automatic logic [15:0] small_coord();
    return 16'($urandom_range(0, 64) - 32);
  endfunction

  // Random face: full range, small box, collinear, axis-aligned, or coincident.
  function automatic tun_pkg::req_t random_face();
    tun_pkg::req_t r;
    int            k;
    r = REQ_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom});
    case ($urandom_range(0, 9))
      0, 1, 2, 3: ;
      4, 5, 6: begin
        r.p1_x = small_coord(); r.p1_y = small_coord(); r.p1_z = small_coord();
        r.p2_x = small_coord(); r.p2_y = small_coord(); r.p2_z = small_coord();
        r.p3_x = small_coord(); r.p3_y = small_coord(); r.p3_z = small_coord();
      end
      7: begin
        k = $urandom_range(0, 4) - 2;
        r.p2_x = r.p1_x + small_coord(); r.p2_y = r.p1_y + small_coord();
        r.p2_z = r.p1_z + small_coord();
        r.p3_x = r.p1_x + 16'(k) * (r.p2_x - r.p1_x);
        r.p3_y = r.p1_y + 16'(k) * (r.p2_y - r.p1_y);
        r.p3_z = r.p1_z + 16'(k) * (r.p2_z - r.p1_z);
      end
      8: begin
        r.p2_z = r.p1_z;
        r.p3_z = r.p1_z;
      end
      default: begin
        r.p2_x = r.p1_x;
        r.p2_y = r.p1_y;
        r.p2_z = r.p1_z;
      end
    endcase
    return r;
  endfunction

  // Directed faces first, then random ones; the tail runs without idling.
  initial begin
    tun_pkg::req_t r;
    sent_count = 0;
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_face(make_face('{0, 0, 0, 256, 0, 0, 0, 256, 0}), 1);
    send_face(make_face('{0, 0, 0, 0, 256, 0, 256, 0, 0}), 1);
    send_face(make_face('{0, 0, 0, 0, 0, 256, 256, 0, 0}), 1);
    send_face(make_face('{0, 0, 0, 0, 256, 0, 0, 0, 256}), 1);
    send_face(make_face('{-32768, -32768, -32768, 32767, -32768, -32768,
                          -32768, 32767, -32768}), 1);
    send_face(make_face('{32767, 32767, 32767, -32768, 32767, 32767,
                          32767, -32768, 32767}), 0);
    send_face(make_face('{-32768, 32767, -32768, 32767, -32768, 32767,
                          32767, 32767, -32768}), 0);
    send_face(make_face('{32767, -32768, 32767, -32768, 32767, -32768,
                          -32768, -32768, 32767}), 1);
    send_face(make_face('{-32768, -32768, -32768, -32768, -32768, -32768,
                          -32768, -32768, -32768}), 1);
    send_face(make_face('{32767, 32767, 32767, 32767, 32767, 32767,
                          32767, 32767, 32767}), 1);
    send_face(make_face('{0, 0, 0, 100, 200, 300, 200, 400, 600}), 1);
    send_face(make_face('{-32768, -32768, -32768, 0, 0, 0, 32767, 32767, 32767}), 1);
    send_face(make_face('{5, 5, 5, 5, 5, 5, 9, 1, -3}), 1);
    send_face(make_face('{0, 0, 0, 3, 0, 0, 0, 4, 0}), 1);
    send_face(make_face('{0, 0, 0, 1, 1, 0, -1, 1, 0}), 0);
    send_face(make_face('{0, 0, 0, 1, 2, 2, 2, 1, -2}), 1);
    send_face(make_face('{1, -1, 1, -1, 1, -1, 1, 1, -1}), 1);
    send_face(make_face('{-1, -1, -1, -32768, 32767, 0, 32767, 0, -32768}), 1);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      r = random_face();
      send_face(r, i < RANDOM_REQUESTS - QUIET_TAIL);
    end
    start <= 1'b0;

    while (pending_normals != 0) @(posedge clk);
    repeat (tun_pkg::LAT + 5) @(posedge clk);

    $display("Sent %0d triangle requests, checked %0d normals, %0d of them degenerate.",
             sent_count, checked_count, degenerate_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/tun_pkg.sv
hdl/tun_cross.sv
hdl/tun_square.sv
hdl/tun_merge.sv
hdl/tun_quot.sv
hdl/triangle_unit_normal_top.sv
hdl/tun_check.sv
tb/triangle_unit_normal_checker.sv
tb/triangle_unit_normal_top_test.sv
